[design/size_aware_lru_cache_defines.svh]
// Assertion macros for the size-aware LRU cache checker.
// Depends on nothing; included by the checker file only.
`ifndef SIZE_AWARE_LRU_CACHE_DEFINES_SVH
`define SIZE_AWARE_LRU_CACHE_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define SALC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication outside reset
`define SALC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/salc_pkg.sv]
// Package for the size-aware LRU cache: payload structs and fixed widths.
// No dependencies.
package salc_pkg;

  localparam int KEY_W   = 48;
  localparam int BYTES_W = 32;
  localparam int WIDE_W  = 48;
  localparam int EVC_W   = 5;

  typedef struct packed {
    logic [KEY_W-1:0]   object_key;
    logic [BYTES_W-1:0] object_bytes;
  } req_t;

  typedef struct packed {
    logic               was_hit;
    logic               was_bypassed;
    logic [EVC_W-1:0]   evicted_count;
    logic [WIDE_W-1:0]  bytes_in_use;
    logic [WIDE_W-1:0]  request_count;
    logic [WIDE_W-1:0]  hit_count;
  } resp_t;

  // Command broadcast from the controller to every cell
  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_TOUCH  = 2'd1;  // hit: promote matched entry
  localparam logic [1:0] CMD_EVICT  = 2'd2;  // drop the LRU entry
  localparam logic [1:0] CMD_INSERT = 2'd3;  // fill the first free slot

  typedef struct packed {
    logic [1:0]         cmd;
    logic [KEY_W-1:0]   key;
    logic [WIDE_W-1:0]  bytes;
  } cell_ctl_t;

endpackage

[design/size_aware_lru_cache.sv]
// Top level of the size-aware LRU cache: a row of slot cells and a sequencer.
// Depends on salc_pkg, salc_cell and salc_ctrl.
//
//  channel  | handshake            | payload
//  request  | start & !busy        | req (object_key, object_bytes)
//  result   | result_valid, 1 cyc  | result (resp_t)
//  config   | cfg_valid & cfg_ready| cfg_data (byte_capacity)
//
// A hit or bypass goes from lookup straight to the result strobe; a miss first
// evicts LRU entries, one per cycle, until the object fits, then inserts it.
// Reset clears valid bits, ranks and counters.
// The result strobe lasts one cycle; the next start is taken once busy falls.
module size_aware_lru_cache #(
  parameter int SLOTS     = 16,
  parameter int SIZE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  salc_pkg::req_t    req,
  output logic              result_valid,
  output salc_pkg::resp_t   result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [47:0]       cfg_data
);
  import salc_pkg::*;

  localparam int RANK_W = $clog2(SLOTS);

  logic [47:0]          capacity;
  cell_ctl_t            ctl;
  logic [RANK_W-1:0]    lru_rank;
  logic [SLOTS:0]       free_ch;
  logic [SIZE_BITS-1:0] lru_ch [SLOTS+1];
  logic [SLOTS-1:0]     match, valid;
  logic [RANK_W-1:0]    rank [SLOTS];
  logic                 any_hit;
  logic [RANK_W-1:0]    hit_rank;
  logic [RANK_W:0]      n_valid;

  assign cfg_ready = !busy;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) capacity <= '0;
    else if (cfg_valid && cfg_ready) capacity <= cfg_data;
  end

  assign free_ch[0] = 1'b0;
  assign lru_ch[0]  = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    salc_cell #(.RANK_W(RANK_W), .SIZE_W(SIZE_BITS)) u_cell (
      .clk(clk), .rst(rst), .ctl(ctl), .lru_rank(lru_rank), .hit_rank(hit_rank),
      .free_in(free_ch[i]), .free_out(free_ch[i+1]),
      .lru_in(lru_ch[i]), .lru_out(lru_ch[i+1]),
      .match(match[i]), .valid(valid[i]), .rank(rank[i])
    );
  end

  // Hit rank and occupancy reduction over the row
  always_comb begin
    hit_rank = '0;
    for (int i = 0; i < SLOTS; i++) if (match[i]) hit_rank = hit_rank | rank[i];
  end
  assign any_hit = |match;
  assign n_valid = (RANK_W+1)'($countones(valid));

  salc_ctrl #(.SLOTS(SLOTS), .RANK_W(RANK_W), .SIZE_W(SIZE_BITS)) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .capacity(capacity), .ctl(ctl), .any_hit(any_hit), .hit_rank(hit_rank),
    .lru_rank(lru_rank), .n_valid(n_valid), .lru_bytes(lru_ch[SLOTS]),
    .done(result_valid), .result(result)
  );
endmodule

[design/salc_cell.sv]
// One directory slot: key, size, valid and recency rank.
// Depends on salc_pkg. Chained to its neighbours through the free-slot
// and LRU-size ripple paths.
module salc_cell #(
  parameter int RANK_W = 4,
  parameter int SIZE_W = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  salc_pkg::cell_ctl_t     ctl,
  input  logic [RANK_W-1:0]       lru_rank,   // rank of the LRU entry
  input  logic [RANK_W-1:0]       hit_rank,   // rank of the matched entry
  input  logic                    free_in,    // a lower cell is free
  output logic                    free_out,
  input  logic [SIZE_W-1:0]       lru_in,     // LRU size from lower cells
  output logic [SIZE_W-1:0]       lru_out,
  output logic                    match,
  output logic                    valid,
  output logic [RANK_W-1:0]       rank
);
  import salc_pkg::*;

  logic [KEY_W-1:0]  key;
  logic [SIZE_W-1:0] bytes;
  logic              is_lru;

  assign match    = valid && (key == ctl.key);
  assign is_lru   = valid && (rank == lru_rank);
  assign free_out = free_in || !valid;
  assign lru_out  = is_lru ? bytes : lru_in;

  // State update per broadcast command
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else begin
      unique case (ctl.cmd)
        CMD_TOUCH: begin
          if (match) rank <= '0;
          else if (valid && rank < hit_rank) rank <= rank + 1'b1;
        end
        CMD_EVICT: begin
          if (is_lru) valid <= 1'b0;
        end
        CMD_INSERT: begin
          if (!valid && !free_in) begin
            valid <= 1'b1;
            rank  <= '0;
          end else if (valid) begin
            rank <= rank + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload captured on insert
  always_ff @(posedge clk) begin
    if (ctl.cmd == CMD_INSERT && !valid && !free_in) begin
      key   <= ctl.key;
      bytes <= ctl.bytes[SIZE_W-1:0];
    end
  end
endmodule

[design/salc_ctrl.sv]
// Request sequencer: lookup, eviction loop, insert, counters and result.
// Depends on salc_pkg; drives the cell row of the top level.
module salc_ctrl #(
  parameter int SLOTS  = 16,
  parameter int RANK_W = 4,
  parameter int SIZE_W = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  salc_pkg::req_t           req,
  input  logic [47:0]              capacity,
  output salc_pkg::cell_ctl_t      ctl,
  input  logic                     any_hit,
  input  logic [RANK_W-1:0]        hit_rank,
  output logic [RANK_W-1:0]        lru_rank,
  input  logic [RANK_W:0]          n_valid,
  input  logic [SIZE_W-1:0]        lru_bytes,
  output logic                     done,
  output salc_pkg::resp_t          result
);
  import salc_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOOKUP = 3'd1;
  localparam logic [2:0] ST_FIT    = 3'd2;
  localparam logic [2:0] ST_INSERT = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]        state;
  logic [KEY_W-1:0]  key;
  logic [WIDE_W-1:0] size;
  logic [WIDE_W-1:0] used;
  logic [WIDE_W-1:0] reqs;
  logic [WIDE_W-1:0] hits;
  logic [EVC_W-1:0]  evc;
  logic              hit_f;
  logic              byp_f;
  logic [WIDE_W:0]   need;
  logic [WIDE_W-1:0] lru_w;
  logic [SIZE_W-1:0] size_sat;

  localparam logic [WIDE_W-1:0] SAT = {WIDE_W{1'b1}};

  assign busy     = (state != ST_IDLE);
  assign need     = {1'b0, used} + {1'b0, size};
  assign lru_w    = WIDE_W'(lru_bytes);
  assign lru_rank = RANK_W'(n_valid - 1'b1);

  // Size saturated to SIZE_W bits
  always_comb begin
    if (BYTES_W > SIZE_W && (req.object_bytes >> SIZE_W) != '0) size_sat = '1;
    else size_sat = SIZE_W'(req.object_bytes);
  end

  // Cell command decode
  always_comb begin
    ctl.key   = key;
    ctl.bytes = size;
    ctl.cmd   = CMD_NONE;
    unique case (state)
      ST_LOOKUP: if (any_hit) ctl.cmd = CMD_TOUCH;
      ST_FIT:
        if (need > {1'b0, capacity} && n_valid != '0) ctl.cmd = CMD_EVICT;
      ST_INSERT:
        if (n_valid == (RANK_W+1)'(SLOTS)) ctl.cmd = CMD_EVICT;
        else ctl.cmd = CMD_INSERT;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used  <= '0;
      reqs  <= '0;
      hits  <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == ST_DONE);
      unique case (state)
        ST_IDLE: if (start) begin
          key   <= req.object_key;
          size  <= WIDE_W'(size_sat);
          evc   <= '0;
          hit_f <= 1'b0;
          byp_f <= 1'b0;
          if (reqs != SAT) reqs <= reqs + 1'b1;
          state <= ST_LOOKUP;
        end
        ST_LOOKUP: begin
          if (any_hit) begin
            hit_f <= 1'b1;
            if (hits != SAT) hits <= hits + 1'b1;
            state <= ST_DONE;
          end else if (size > capacity) begin
            byp_f <= 1'b1;
            state <= ST_DONE;
          end else state <= ST_FIT;
        end
        ST_FIT: begin
          // one LRU eviction per cycle until the object fits
          if (ctl.cmd == CMD_EVICT) begin
            used <= (used >= lru_w) ? used - lru_w : '0;
            evc  <= evc + 1'b1;
          end else state <= ST_INSERT;
        end
        ST_INSERT: begin
          if (ctl.cmd == CMD_EVICT) begin
            used <= (used >= lru_w) ? used - lru_w : '0;
            evc  <= evc + 1'b1;
          end else begin
            used  <= need[WIDE_W-1:0];
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    result.was_hit       = hit_f;
    result.was_bypassed  = byp_f;
    result.evicted_count = evc;
    result.bytes_in_use  = used;
    result.request_count = reqs;
    result.hit_count     = hits;
  end
endmodule

[design/salc_checker.sv]
// Port-level checker for the size-aware LRU cache, bound to the top level.
// Depends on salc_pkg and size_aware_lru_cache_defines.svh.
`include "size_aware_lru_cache_defines.svh"

module salc_checker (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            result_valid,
  input salc_pkg::resp_t result
);
  import salc_pkg::*;

  // a transfer in always makes the block busy
  `SALC_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  // a result is never both hit and bypass
  `SALC_ASSERT_IMP(a_hit_byp, result_valid, !(result.was_hit && result.was_bypassed))
  // hits and bypasses evict nothing
  `SALC_ASSERT_IMP(a_no_evict, result_valid && (result.was_hit || result.was_bypassed),
                   result.evicted_count == '0)
  // strobe is a single pulse
  `SALC_ASSERT_NEXT(a_pulse, result_valid, !result_valid)
endmodule

bind size_aware_lru_cache salc_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .result_valid(result_valid), .result(result)
);
